/* sv/iee_pkg.sv */
package iee_pkg;

	// character codes the evaluator reacts to
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int OUT_WIDTH = 32;

	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_MUL  = 2'd1,
		PEND_DIV  = 2'd2
	} pend_t;

	// what the character that closed the current operand asks for
	typedef enum logic [2:0] {
		OP_MUL,
		OP_DIV,
		OP_ADD,
		OP_SUB,
		OP_END
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DFIX,
		ST_POST
	} state_t;

endpackage

/* sv/infix_expression_evaluator_core.sv */
// channel   | direction | tdata                  | tuser
// s_axis    | in        | [7:0] ch               | -
// m_axis    | out       | [31:0] value           | [0] div_zero
//
// a space or a digit is absorbed in the idle state; an operator with no pending * or / goes to the closing step
// a pending * runs a shift-add multiplier one multiplier bit per cycle;
//   a pending / runs a restoring divider one quotient bit per cycle,
//   then a sign fix-up step (a zero divisor skips the divider)
// arst_n clears the whole expression state and drops m_axis_tvalid
// a terminator waits in the closing step while an earlier result is not taken
module infix_expression_evaluator_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,   // [7:0] ch
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [iee_pkg::OUT_WIDTH-1:0]    m_axis_tdata,   // [31:0] value
	output logic [0:0]                       m_axis_tuser    // [0] div_zero
);

	localparam int CNT_W = $clog2(VALUE_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

	iee_pkg::state_t state_q, state_d;
	iee_pkg::pend_t  pend_q;
	iee_pkg::op_t    op_q;
	iee_pkg::op_t    op_dec;

	logic [VALUE_WIDTH-1:0] cur_q, term_q, sum_q, acc_q, rem_q;
	logic                   add_sign_q, zdiv_q, neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   out_valid_q;
	logic [iee_pkg::OUT_WIDTH-1:0] out_value_q;
	logic                   out_zdiv_q;

	logic                   acc_in, is_space, is_digit;
	logic [7:0]             ch;
	logic [VALUE_WIDTH-1:0] cur_x10, acc_n, sum_n, term_abs, cur_abs;
	logic [VALUE_WIDTH:0]   trial, diff;
	logic                   qbit, emit, last_step;
	logic [63:0]            sum_ext;

	assign ch     = s_axis_tdata;
	assign acc_in = s_axis_tvalid && s_axis_tready;

	always_comb begin
		is_space = (ch == iee_pkg::CH_SPACE);
		is_digit = ch inside {[iee_pkg::CH_ZERO:iee_pkg::CH_NINE]};
		case (ch)
			iee_pkg::CH_STAR:  op_dec = iee_pkg::OP_MUL;
			iee_pkg::CH_SLASH: op_dec = iee_pkg::OP_DIV;
			iee_pkg::CH_PLUS:  op_dec = iee_pkg::OP_ADD;
			iee_pkg::CH_MINUS: op_dec = iee_pkg::OP_SUB;
			default:           op_dec = iee_pkg::OP_END;
		endcase
	end

	// datapath helpers
	always_comb begin
		cur_x10  = (cur_q << 3) + (cur_q << 1) + VALUE_WIDTH'(ch - iee_pkg::CH_ZERO);
		acc_n    = cur_q[0] ? (acc_q + term_q) : acc_q;
		term_abs = term_q[VALUE_WIDTH-1] ? (-term_q) : term_q;
		cur_abs  = cur_q[VALUE_WIDTH-1] ? (-cur_q) : cur_q;
		trial    = {rem_q, term_q[VALUE_WIDTH-1]};
		diff     = trial - {1'b0, cur_q};
		qbit     = ~diff[VALUE_WIDTH];
		sum_n    = add_sign_q ? (sum_q - term_q) : (sum_q + term_q);
		sum_ext  = 64'(signed'(sum_n));
		last_step = (cnt_q == '0);
		emit     = (state_q == iee_pkg::ST_POST) && (op_q == iee_pkg::OP_END) &&
		           (!out_valid_q || m_axis_tready);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			iee_pkg::ST_IDLE: begin
				if (acc_in && !is_space && !is_digit) begin
					case (pend_q)
						iee_pkg::PEND_MUL: state_d = iee_pkg::ST_MUL;
						iee_pkg::PEND_DIV: state_d = (cur_q == '0) ? iee_pkg::ST_POST
						                                           : iee_pkg::ST_DIV;
						default:           state_d = iee_pkg::ST_POST;
					endcase
				end
			end
			iee_pkg::ST_MUL:  if (last_step) state_d = iee_pkg::ST_POST;
			iee_pkg::ST_DIV:  if (last_step) state_d = iee_pkg::ST_DFIX;
			iee_pkg::ST_DFIX: state_d = iee_pkg::ST_POST;
			iee_pkg::ST_POST: begin
				if (op_q != iee_pkg::OP_END || emit) state_d = iee_pkg::ST_IDLE;
			end
			default: state_d = iee_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = (state_q == iee_pkg::ST_IDLE);
		m_axis_tvalid = out_valid_q;
		m_axis_tdata  = out_value_q;
		m_axis_tuser  = out_zdiv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iee_pkg::ST_IDLE;
			pend_q      <= iee_pkg::PEND_NONE;
			op_q        <= iee_pkg::OP_END;
			cur_q       <= '0;
			term_q      <= '0;
			sum_q       <= '0;
			add_sign_q  <= 1'b0;
			zdiv_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				iee_pkg::ST_IDLE: begin
					if (acc_in && is_digit) begin
						cur_q <= cur_x10;
					end else if (acc_in && !is_space) begin
						op_q <= op_dec;
						case (pend_q)
							iee_pkg::PEND_MUL: ;
							iee_pkg::PEND_DIV: begin
								if (cur_q == '0) begin
									zdiv_q <= 1'b1;
									term_q <= '0;
								end else begin
									term_q <= term_abs;
									cur_q  <= cur_abs;
								end
							end
							default: begin
								term_q <= cur_q;
								cur_q  <= '0;
							end
						endcase
					end
				end
				iee_pkg::ST_MUL: begin
					// multiplier bits leave cur_q lsb first, so it ends at zero
					cur_q  <= cur_q >> 1;
					term_q <= last_step ? acc_n : (term_q << 1);
				end
				iee_pkg::ST_DIV: begin
					term_q <= {term_q[VALUE_WIDTH-2:0], qbit};
				end
				iee_pkg::ST_DFIX: begin
					term_q <= neg_q ? (-term_q) : term_q;
					cur_q  <= '0;
				end
				iee_pkg::ST_POST: begin
					case (op_q)
						iee_pkg::OP_MUL: pend_q <= iee_pkg::PEND_MUL;
						iee_pkg::OP_DIV: pend_q <= iee_pkg::PEND_DIV;
						iee_pkg::OP_ADD, iee_pkg::OP_SUB: begin
							sum_q      <= sum_n;
							term_q     <= '0;
							pend_q     <= iee_pkg::PEND_NONE;
							add_sign_q <= (op_q == iee_pkg::OP_SUB);
						end
						default: begin
							if (emit) begin
								sum_q       <= '0;
								term_q      <= '0;
								pend_q      <= iee_pkg::PEND_NONE;
								add_sign_q  <= 1'b0;
								zdiv_q      <= 1'b0;
							end
						end
					endcase
				end
				default: ;
			endcase
		end
	end

	// iteration registers and result holding, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == iee_pkg::ST_IDLE && acc_in && !is_space && !is_digit) begin
			cnt_q <= CNT_LAST;
			acc_q <= '0;
			rem_q <= '0;
			neg_q <= term_q[VALUE_WIDTH-1] ^ cur_q[VALUE_WIDTH-1];
		end else begin
			if (state_q == iee_pkg::ST_MUL || state_q == iee_pkg::ST_DIV) cnt_q <= cnt_q - 1'b1;
			if (state_q == iee_pkg::ST_MUL) acc_q <= acc_n;
			if (state_q == iee_pkg::ST_DIV)
				rem_q <= qbit ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
		end
		if (emit) begin
			out_value_q <= sum_ext[iee_pkg::OUT_WIDTH-1:0];
			out_zdiv_q  <= zdiv_q;
		end
	end

	// partial remainder stays below the divisor throughout the division
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == iee_pkg::ST_DIV |-> rem_q < cur_q)
		else $error("remainder not below divisor");

	// a zero divisor raises the flag at once
	a_zero_div_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && !is_space && !is_digit && pend_q == iee_pkg::PEND_DIV && cur_q == '0)
		|=> zdiv_q)
		else $error("division by zero not flagged");

	// the multiplier operand is fully consumed when the product is ready
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == iee_pkg::ST_MUL && last_step) |=> state_q == iee_pkg::ST_POST && cur_q == '0)
		else $error("multiply did not finish cleanly");

	// a delivered result leaves a cleared expression behind
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> sum_q == '0 && term_q == '0 && !zdiv_q && out_valid_q)
		else $error("state not cleared after result");

endmodule
